// ----- sv/alt_pkg.sv -----
// Shared types, constants and helper functions for the allocation leak tracker.
`default_nettype none

package alt_pkg;

   // Table geometry and stored address width.
   localparam int TABLE_DEPTH = 32;
   localparam int ADDR_BITS   = 32;

   // Counter width holds 0..TABLE_DEPTH; index width addresses the table.
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   // Fixed field widths of the transactions.
   localparam int ADDR_W   = 32;
   localparam int FILE_W   = 16;
   localparam int LINE_W   = 24;
   localparam int TOTAL_W  = 6;
   localparam int ENTRY_W  = ADDR_BITS + FILE_W + LINE_W;

   typedef enum logic [1:0] {
      OP_ALLOC  = 2'd0,
      OP_FREE   = 2'd1,
      OP_REPORT = 2'd2,
      OP_NONE   = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_NOT_LIVE = 3'd1,
      ST_NO_ALLOC = 3'd2,
      ST_FULL     = 3'd3,
      ST_ENTRY    = 3'd4,
      ST_DONE     = 3'd5
   } status_type;

   // One stored table entry.
   typedef struct packed {
      logic [ADDR_BITS-1:0] addr;
      logic [FILE_W-1:0]    file;
      logic [LINE_W-1:0]    line;
   } entry_type;

   // One result transaction.
   typedef struct packed {
      status_type         status;
      logic [ADDR_W-1:0]  address;
      logic [FILE_W-1:0]  file;
      logic [LINE_W-1:0]  line;
      logic [TOTAL_W-1:0] live_total;
      logic               last;
   } rsp_type;

   // Access to the entry memory from the sequencer.
   typedef struct packed {
      logic               wr_en;
      logic [IDX_W-1:0]   wr_addr;
      entry_type          wr_data;
      logic               rd_en;
      logic [IDX_W-1:0]   rd_addr;
   } ram_req_type;

   // Bring a port address to the stored address width.
   function automatic logic [ADDR_BITS-1:0] mask_addr(input logic [ADDR_W-1:0] a);
      logic [63:0] w;
      w = 64'(a);
      return w[ADDR_BITS-1:0];
   endfunction

   // Bring a stored address to the port width.
   function automatic logic [ADDR_W-1:0] port_addr(input logic [ADDR_BITS-1:0] a);
      logic [63:0] w;
      w = 64'(a);
      return w[ADDR_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ----- sv/alt_ram.sv -----
// Generic single-write, single-read memory with a registered read port.
`default_nettype none

module alt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic                                   rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port; read data holds while rd_en is low.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- sv/alt_engine.sv -----
// Sequencer that walks the entry table with one shared address comparator.
`default_nettype none

module alt_engine (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic [1:0]                 req_opcode,
   input  wire logic [alt_pkg::ADDR_W-1:0] req_address,
   input  wire logic [alt_pkg::FILE_W-1:0] req_site_file,
   input  wire logic [alt_pkg::LINE_W-1:0] req_site_line,
   input  wire logic                       slot_free,
   output logic                            push,
   output alt_pkg::rsp_type                result,
   output alt_pkg::ram_req_type            ram_req,
   input  wire alt_pkg::entry_type         ram_rd_data
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECIDE,
      S_SCAN,
      S_SHIFT,
      S_REPORT,
      S_DONE,
      S_FINISH
   } state_type;

   localparam int CW = alt_pkg::CNT_W;
   localparam int IW = alt_pkg::IDX_W;

   state_type                        state_ff, state_in;
   alt_pkg::opcode_type              op_ff, op_in;
   logic [alt_pkg::ADDR_BITS-1:0]    key_ff, key_in;
   logic [alt_pkg::FILE_W-1:0]       file_ff, file_in;
   logic [alt_pkg::LINE_W-1:0]       line_ff, line_in;
   alt_pkg::status_type              status_ff, status_in;
   logic [CW-1:0]                    total_ff, total_in;
   logic                             started_ff, started_in;
   logic [CW-1:0]                    idx_ff, idx_in;

   logic [CW-1:0] idx_next;
   logic [CW-1:0] idx_next2;
   logic [CW-1:0] total_dec;
   logic          idx_last;
   logic          next_last;
   logic          key_hit;

   // Index arithmetic and the shared address comparator.
   assign idx_next  = idx_ff + CW'(1);
   assign idx_next2 = idx_ff + CW'(2);
   assign total_dec = total_ff - CW'(1);
   assign idx_last  = (idx_ff == total_dec);
   assign next_last = (idx_next == total_dec);
   assign key_hit   = (ram_rd_data.addr == key_ff);

   assign req_stall = (state_ff != S_IDLE);

   // Next-state, memory access and result logic.
   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      key_in     = key_ff;
      file_in    = file_ff;
      line_in    = line_ff;
      status_in  = status_ff;
      total_in   = total_ff;
      started_in = started_ff;
      idx_in     = idx_ff;

      push              = 1'b0;
      result            = '0;
      result.status     = status_ff;
      result.live_total = alt_pkg::TOTAL_W'(total_ff);

      ram_req         = '0;
      ram_req.wr_addr = idx_ff[IW-1:0];
      ram_req.rd_addr = idx_next[IW-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in    = alt_pkg::opcode_type'(req_opcode);
               key_in   = alt_pkg::mask_addr(req_address);
               file_in  = req_site_file;
               line_in  = req_site_line;
               state_in = S_DECIDE;
            end
         end

         S_DECIDE: begin
            unique case (op_ff)
               alt_pkg::OP_ALLOC: begin
                  started_in = 1'b1;
                  state_in   = S_FINISH;
                  if (total_ff == CW'(alt_pkg::TABLE_DEPTH)) begin
                     status_in = alt_pkg::ST_FULL;
                  end else begin
                     ram_req.wr_en        = 1'b1;
                     ram_req.wr_addr      = total_ff[IW-1:0];
                     ram_req.wr_data.addr = key_ff;
                     ram_req.wr_data.file = file_ff;
                     ram_req.wr_data.line = line_ff;
                     total_in             = total_ff + CW'(1);
                     status_in            = alt_pkg::ST_OK;
                  end
               end
               alt_pkg::OP_FREE: begin
                  if (!started_ff) begin
                     status_in = alt_pkg::ST_NO_ALLOC;
                     state_in  = S_FINISH;
                  end else if (total_ff == '0) begin
                     status_in = alt_pkg::ST_NOT_LIVE;
                     state_in  = S_FINISH;
                  end else begin
                     idx_in          = '0;
                     ram_req.rd_en   = 1'b1;
                     ram_req.rd_addr = '0;
                     state_in        = S_SCAN;
                  end
               end
               alt_pkg::OP_REPORT: begin
                  idx_in = '0;
                  if (total_ff == '0) begin
                     state_in = S_DONE;
                  end else begin
                     ram_req.rd_en   = 1'b1;
                     ram_req.rd_addr = '0;
                     state_in        = S_REPORT;
                  end
               end
               alt_pkg::OP_NONE: begin
                  status_in = alt_pkg::ST_OK;
                  state_in  = S_FINISH;
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end

         // Look for the oldest live entry with a matching address.
         S_SCAN: begin
            if (key_hit) begin
               if (idx_last) begin
                  total_in  = total_dec;
                  status_in = alt_pkg::ST_OK;
                  state_in  = S_FINISH;
               end else begin
                  ram_req.rd_en   = 1'b1;
                  ram_req.rd_addr = idx_next[IW-1:0];
                  state_in        = S_SHIFT;
               end
            end else if (idx_last) begin
               status_in = alt_pkg::ST_NOT_LIVE;
               state_in  = S_FINISH;
            end else begin
               ram_req.rd_en   = 1'b1;
               ram_req.rd_addr = idx_next[IW-1:0];
               idx_in          = idx_next;
            end
         end

         // Close up the gap: the entry read behind the index moves down one slot.
         S_SHIFT: begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = idx_ff[IW-1:0];
            ram_req.wr_data = ram_rd_data;
            if (next_last) begin
               total_in  = total_dec;
               status_in = alt_pkg::ST_OK;
               state_in  = S_FINISH;
            end else begin
               ram_req.rd_en   = 1'b1;
               ram_req.rd_addr = idx_next2[IW-1:0];
               idx_in          = idx_next;
            end
         end

         // Emit one live entry per free output slot, oldest first.
         S_REPORT: begin
            if (slot_free) begin
               push           = 1'b1;
               result.status  = alt_pkg::ST_ENTRY;
               result.address = alt_pkg::port_addr(ram_rd_data.addr);
               result.file    = ram_rd_data.file;
               result.line    = ram_rd_data.line;
               if (idx_last) begin
                  state_in = S_DONE;
               end else begin
                  ram_req.rd_en   = 1'b1;
                  ram_req.rd_addr = idx_next[IW-1:0];
                  idx_in          = idx_next;
               end
            end
         end

         // Closing count of a report; the table empties afterward.
         S_DONE: begin
            if (slot_free) begin
               push          = 1'b1;
               result.status = alt_pkg::ST_DONE;
               result.last   = 1'b1;
               total_in      = '0;
               started_in    = 1'b0;
               state_in      = S_IDLE;
            end
         end

         S_FINISH: begin
            if (slot_free) begin
               push        = 1'b1;
               result.last = 1'b1;
               state_in    = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State, counters and the latched request.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         total_ff   <= '0;
         started_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         total_ff   <= total_in;
         started_ff <= started_in;
      end
      op_ff     <= op_in;
      key_ff    <= key_in;
      file_ff   <= file_in;
      line_ff   <= line_in;
      status_ff <= status_in;
      idx_ff    <= idx_in;
   end

endmodule

`default_nettype wire

// ----- sv/allocation_leak_tracker.sv -----
// Top level of the allocation leak tracker: entry memory, sequencer and result register.
`default_nettype none

// Tracks up to TABLE_DEPTH live allocations in insertion order in a one-read,
// one-write entry memory that a sequencer walks with a single address
// comparator; one request is worked on at a time and req_stall stays high
// until its last response has been loaded into the response register. A free
// compares live entries oldest first and, on a match, moves each younger entry
// down one slot to close the gap (compared plus moved never exceeds the live
// count), and a report reads the live entries from the memory port one after
// another, oldest first, and then gives the closing count.
// Responses leave through one output register, so the next response can be
// loaded in the cycle the current one is taken. Memory contents need no
// clearing after reset: only slots below the live count are ever read.
module allocation_leak_tracker (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [1:0]                  req_opcode,
   input  wire logic [alt_pkg::ADDR_W-1:0]  req_address,
   input  wire logic [alt_pkg::FILE_W-1:0]  req_site_file,
   input  wire logic [alt_pkg::LINE_W-1:0]  req_site_line,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [2:0]                       rsp_status,
   output logic [alt_pkg::ADDR_W-1:0]       rsp_leaked_address,
   output logic [alt_pkg::FILE_W-1:0]       rsp_leaked_file,
   output logic [alt_pkg::LINE_W-1:0]       rsp_leaked_line,
   output logic [alt_pkg::TOTAL_W-1:0]      rsp_live_total,
   output logic                             rsp_last
);

   alt_pkg::ram_req_type ram_req;
   alt_pkg::entry_type   ram_rd_data;
   logic [alt_pkg::ENTRY_W-1:0] ram_rd_raw;
   alt_pkg::rsp_type     result;
   logic                 push;
   logic                 slot_free;

   logic                 rsp_valid_ff, rsp_valid_in;
   alt_pkg::rsp_type     rsp_data_ff, rsp_data_in;

   // Entry table storage.
   alt_ram #(
      .WIDTH (alt_pkg::ENTRY_W),
      .DEPTH (alt_pkg::TABLE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_req.wr_en),
      .wr_addr (ram_req.wr_addr),
      .wr_data (ram_req.wr_data),
      .rd_en   (ram_req.rd_en),
      .rd_addr (ram_req.rd_addr),
      .rd_data (ram_rd_raw)
   );

   assign ram_rd_data = alt_pkg::entry_type'(ram_rd_raw);

   // Request sequencer.
   alt_engine u_engine (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_opcode    (req_opcode),
      .req_address   (req_address),
      .req_site_file (req_site_file),
      .req_site_line (req_site_line),
      .slot_free     (slot_free),
      .push          (push),
      .result        (result),
      .ram_req       (ram_req),
      .ram_rd_data   (ram_rd_data)
   );

   // The response register can take a new transaction when empty or being drained.
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (push) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   // Response ports.
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_data_ff.status;
   assign rsp_leaked_address = rsp_data_ff.address;
   assign rsp_leaked_file    = rsp_data_ff.file;
   assign rsp_leaked_line    = rsp_data_ff.line;
   assign rsp_live_total     = rsp_data_ff.live_total;
   assign rsp_last           = rsp_data_ff.last;

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the allocation leak tracker, with a shadow table as predictor.
module tb_top;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DRAIN_CYCLES = 2 * alt_pkg::TABLE_DEPTH + 16;
   localparam int PHASE_ITEMS  = 55;
   localparam int PRINT_LIMIT  = 60;

   // Clock, reset and the block's ports.
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_opcode = '0;
   logic [alt_pkg::ADDR_W-1:0] req_address = '0;
   logic [alt_pkg::FILE_W-1:0] req_site_file = '0;
   logic [alt_pkg::LINE_W-1:0] req_site_line = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [2:0] rsp_status;
   logic [alt_pkg::ADDR_W-1:0] rsp_leaked_address;
   logic [alt_pkg::FILE_W-1:0] rsp_leaked_file;
   logic [alt_pkg::LINE_W-1:0] rsp_leaked_line;
   logic [alt_pkg::TOTAL_W-1:0] rsp_live_total;
   logic rsp_last;

   // Shadow copy of the allocation table, live entries kept oldest first.
   logic [alt_pkg::ADDR_W-1:0] shadow_addr [alt_pkg::TABLE_DEPTH];
   logic [alt_pkg::FILE_W-1:0] shadow_file [alt_pkg::TABLE_DEPTH];
   logic [alt_pkg::LINE_W-1:0] shadow_line [alt_pkg::TABLE_DEPTH];
   int live_count = 0;
   bit alloc_seen = 1'b0;
   alt_pkg::rsp_type pending_responses [$];
   alt_pkg::rsp_type want_response;

   // Run bookkeeping.
   int error_count = 0;
   int sent_count = 0;
   int checked_count = 0;
   int report_count = 0;
   int full_count = 0;
   int not_live_count = 0;
   int no_alloc_count = 0;
   int cycle_count = 0;
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;

   always #5 clock = ~clock;

   allocation_leak_tracker u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_opcode         (req_opcode),
      .req_address        (req_address),
      .req_site_file      (req_site_file),
      .req_site_line      (req_site_line),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_leaked_address (rsp_leaked_address),
      .rsp_leaked_file    (rsp_leaked_file),
      .rsp_leaked_line    (rsp_leaked_line),
      .rsp_live_total     (rsp_live_total),
      .rsp_last           (rsp_last)
   );

   // Builds one expected response.
   function automatic alt_pkg::rsp_type make_response(alt_pkg::status_type st,
                                                      logic [alt_pkg::ADDR_W-1:0] a,
                                                      logic [alt_pkg::FILE_W-1:0] f,
                                                      logic [alt_pkg::LINE_W-1:0] l,
                                                      int total, logic fin);
      alt_pkg::rsp_type r;
      r.status     = st;
      r.address    = a;
      r.file       = f;
      r.line       = l;
      r.live_total = alt_pkg::TOTAL_W'(total);
      r.last       = fin;
      return r;
   endfunction

   // Random site fields at the port widths.
   function automatic logic [alt_pkg::FILE_W-1:0] rand_file();
      return alt_pkg::FILE_W'($urandom_range(16'hFFFF));
   endfunction

   function automatic logic [alt_pkg::LINE_W-1:0] rand_line();
      return alt_pkg::LINE_W'($urandom_range(24'hFFFFFF));
   endfunction

   // Returns the address of a randomly chosen live entry; the table must not be empty.
   function automatic logic [alt_pkg::ADDR_W-1:0] pick_live_address();
      return shadow_addr[$urandom_range(live_count - 1)];
   endfunction

   // Applies one accepted request to the shadow table and queues the responses it causes.
   task automatic track_request(alt_pkg::opcode_type op, logic [alt_pkg::ADDR_W-1:0] addr,
                                logic [alt_pkg::FILE_W-1:0] file,
                                logic [alt_pkg::LINE_W-1:0] line);
      int hit;
      hit = -1;
      case (op)
         alt_pkg::OP_ALLOC: begin
            alloc_seen = 1'b1;
            if (live_count >= alt_pkg::TABLE_DEPTH) begin
               full_count++;
               pending_responses.push_back(make_response(alt_pkg::ST_FULL, '0, '0, '0,
                                                         live_count, 1'b1));
            end else begin
               shadow_addr[live_count] = addr;
               shadow_file[live_count] = file;
               shadow_line[live_count] = line;
               live_count++;
               pending_responses.push_back(make_response(alt_pkg::ST_OK, '0, '0, '0,
                                                         live_count, 1'b1));
            end
         end
         alt_pkg::OP_FREE: begin
            if (!alloc_seen) begin
               no_alloc_count++;
               pending_responses.push_back(make_response(alt_pkg::ST_NO_ALLOC, '0, '0, '0,
                                                         live_count, 1'b1));
            end else begin
               // The oldest matching entry is retired and the younger ones close up.
               for (int i = 0; i < live_count && hit < 0; i++) begin
                  if (shadow_addr[i] == addr) hit = i;
               end
               if (hit < 0) begin
                  not_live_count++;
                  pending_responses.push_back(make_response(alt_pkg::ST_NOT_LIVE, '0, '0, '0,
                                                            live_count, 1'b1));
               end else begin
                  for (int i = hit; i + 1 < live_count; i++) begin
                     shadow_addr[i] = shadow_addr[i + 1];
                     shadow_file[i] = shadow_file[i + 1];
                     shadow_line[i] = shadow_line[i + 1];
                  end
                  live_count--;
                  pending_responses.push_back(make_response(alt_pkg::ST_OK, '0, '0, '0,
                                                            live_count, 1'b1));
               end
            end
         end
         alt_pkg::OP_REPORT: begin
            // Every live entry oldest first, then the closing count, then an empty table.
            report_count++;
            for (int i = 0; i < live_count; i++) begin
               pending_responses.push_back(make_response(alt_pkg::ST_ENTRY, shadow_addr[i],
                                                         shadow_file[i], shadow_line[i],
                                                         live_count, 1'b0));
            end
            pending_responses.push_back(make_response(alt_pkg::ST_DONE, '0, '0, '0,
                                                      live_count, 1'b1));
            live_count = 0;
            alloc_seen = 1'b0;
         end
         default: begin
            pending_responses.push_back(make_response(alt_pkg::ST_OK, '0, '0, '0,
                                                      live_count, 1'b1));
         end
      endcase
   endtask

   // Sends one request transaction, with random idle cycles ahead of it.
   task automatic send_request(alt_pkg::opcode_type op, logic [alt_pkg::ADDR_W-1:0] addr,
                               logic [alt_pkg::FILE_W-1:0] file,
                               logic [alt_pkg::LINE_W-1:0] line);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_opcode    <= op;
      req_address   <= addr;
      req_site_file <= file;
      req_site_line <= line;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_count++;
      track_request(op, addr, file, line);
   endtask

   // Lowers the request valid and waits until every expected response has arrived.
   task automatic wait_for_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_responses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_idling(int sender_pct, int receiver_pct);
      sender_idle_pct    = sender_pct;
      receiver_stall_pct = receiver_pct;
   endtask

   // Prints one mismatch line and counts it.
   task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
      error_count++;
      if (error_count <= PRINT_LIMIT) begin
         $display("mismatch at response %0d: %s is 0x%0h, expected 0x%0h",
                  checked_count, what, got, want);
      end
   endtask

   // Receiver stalls at random at the rate of the current phase.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
   end

   // Compares each accepted response with the oldest expected one.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_responses.size() == 0) begin
            report_mismatch("unexpected response, status", rsp_status, 0);
         end else begin
            want_response = pending_responses.pop_front();
            if (rsp_status !== want_response.status)
               report_mismatch("status", rsp_status, want_response.status);
            if (rsp_leaked_address !== want_response.address)
               report_mismatch("leaked_address", rsp_leaked_address, want_response.address);
            if (rsp_leaked_file !== want_response.file)
               report_mismatch("leaked_file", rsp_leaked_file, want_response.file);
            if (rsp_leaked_line !== want_response.line)
               report_mismatch("leaked_line", rsp_leaked_line, want_response.line);
            if (rsp_live_total !== want_response.live_total)
               report_mismatch("live_total", rsp_live_total, want_response.live_total);
            if (rsp_last !== want_response.last)
               report_mismatch("last", rsp_last, want_response.last);
         end
         checked_count++;
      end
   end

   // Ends a run that hangs.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, pending_responses.size());
         $display("tb: failure");
         $finish;
      end
   end

   // Frees, reports and the unused opcode on a tracker that has seen no alloc.
   task automatic test_empty_tracker();
      send_request(alt_pkg::OP_FREE, 32'h0000_1234, 16'h0001, 24'h000001);
      send_request(alt_pkg::OP_NONE, 32'h0000_1234, 16'h0001, 24'h000001);
      send_request(alt_pkg::OP_FREE, 32'h0000_0000, 16'h0000, 24'h000000);
      send_request(alt_pkg::OP_REPORT, 32'hFFFF_FFFF, 16'hFFFF, 24'hFFFFFF);
   endtask

   // Extreme field values go in by alloc and come back out by report.
   task automatic test_field_extremes();
      send_request(alt_pkg::OP_ALLOC, 32'h0000_0000, 16'h0000, 24'h000000);
      send_request(alt_pkg::OP_ALLOC, 32'hFFFF_FFFF, 16'hFFFF, 24'hFFFFFF);
      send_request(alt_pkg::OP_ALLOC, 32'h5A5A_A5A5, 16'hA55A, 24'h5AA55A);
      send_request(alt_pkg::OP_FREE, 32'hDEAD_BEEF, 16'h0000, 24'h000000);
      send_request(alt_pkg::OP_NONE, 32'hFFFF_FFFF, 16'hFFFF, 24'hFFFFFF);
      send_request(alt_pkg::OP_REPORT, 32'h0000_0000, 16'h0000, 24'h000000);
      send_request(alt_pkg::OP_FREE, 32'hFFFF_FFFF, 16'hFFFF, 24'hFFFFFF);
   endtask

   // Duplicate live addresses retire oldest first, and a double free is refused.
   task automatic test_duplicate_free();
      send_request(alt_pkg::OP_ALLOC, 32'h1000_0040, 16'h0011, 24'h000101);
      send_request(alt_pkg::OP_ALLOC, 32'h1000_0080, 16'h0012, 24'h000202);
      send_request(alt_pkg::OP_ALLOC, 32'h1000_0040, 16'h0013, 24'h000303);
      send_request(alt_pkg::OP_FREE, 32'h1000_0040, 16'h0020, 24'h000404);
      send_request(alt_pkg::OP_FREE, 32'h1000_0040, 16'h0021, 24'h000505);
      send_request(alt_pkg::OP_FREE, 32'h1000_0040, 16'h0022, 24'h000606);
      send_request(alt_pkg::OP_ALLOC, 32'h1000_00C0, 16'h0014, 24'h000707);
      send_request(alt_pkg::OP_REPORT, 32'h0000_0000, 16'h0000, 24'h000000);
   endtask

   // Fills the table with random entries, overflows it, frees one and refills.
   task automatic test_table_full();
      set_idling(28, 28);
      while (live_count < alt_pkg::TABLE_DEPTH) begin
         send_request(alt_pkg::OP_ALLOC, $urandom(), rand_file(), rand_line());
      end
      send_request(alt_pkg::OP_ALLOC, $urandom(), rand_file(), rand_line());
      send_request(alt_pkg::OP_FREE, pick_live_address(), rand_file(), rand_line());
      send_request(alt_pkg::OP_ALLOC, $urandom(), rand_file(), rand_line());
      send_request(alt_pkg::OP_ALLOC, $urandom(), rand_file(), rand_line());
      send_request(alt_pkg::OP_REPORT, $urandom(), rand_file(), rand_line());
   endtask

   // Mostly allocs and frees of live addresses, with stray frees, reports and the unused opcode.
   task automatic test_random_traffic(int sender_pct, int receiver_pct, int count);
      int roll;
      logic [alt_pkg::ADDR_W-1:0] addr;
      set_idling(sender_pct, receiver_pct);
      repeat (count) begin
         roll = $urandom_range(99);
         addr = $urandom();
         if (roll < 45) begin
            if (live_count > 0 && $urandom_range(3) == 0) addr = pick_live_address();
            send_request(alt_pkg::OP_ALLOC, addr, rand_file(), rand_line());
         end else if (roll < 83) begin
            if (live_count > 0 && $urandom_range(3) != 0) addr = pick_live_address();
            send_request(alt_pkg::OP_FREE, addr, rand_file(), rand_line());
         end else if (roll < 93) begin
            send_request(alt_pkg::OP_REPORT, addr, rand_file(), rand_line());
         end else begin
            send_request(alt_pkg::OP_NONE, addr, rand_file(), rand_line());
         end
      end
   endtask

   // Test sequence.
   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      set_idling(0, 0);
      test_empty_tracker();
      test_field_extremes();
      test_duplicate_free();
      test_table_full();
      test_random_traffic(0, 0, PHASE_ITEMS);
      test_random_traffic(50, 0, PHASE_ITEMS);
      test_random_traffic(0, 50, PHASE_ITEMS);
      test_random_traffic(28, 28, PHASE_ITEMS);
      wait_for_drain();

      $display("Run covered %0d requests and %0d responses, %0d of them reports.",
               sent_count, checked_count, report_count);
      $display("Seen: %0d allocs into a full table, %0d unknown frees, %0d frees before alloc.",
               full_count, not_live_count, no_alloc_count);
      if (error_count == 0 && pending_responses.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
